// File: rtl/wildcard_pattern_matcher_core_defines.svh
// assertion macros for the wildcard pattern matcher
// no dependencies; included by the core before its module header
`ifndef WILDCARD_PATTERN_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, checking suspended in reset
`define WPM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wpm assertion failed");

// next-cycle implication, checking suspended in reset
`define WPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wpm assertion failed");

`endif

// File: rtl/wpm_pkg.sv
// shared types and constants for the wildcard pattern matcher
// no dependencies
package wpm_pkg;

  localparam int CHAR_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_POS_W  = 32;
  localparam int MASK_W     = 16;
  localparam int LEN_REG_W  = 5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARS_LOW  = 2'd0,
    CFG_CHARS_HIGH = 2'd1,
    CFG_WILD_MASK  = 2'd2,
    CFG_PAT_LEN    = 2'd3
  } cfg_reg_t;

endpackage

// File: rtl/wildcard_pattern_matcher_core.sv
// wildcard pattern matcher top level: input register, window compare, result register
// depends on wpm_pkg and wildcard_pattern_matcher_core_defines.svh
`include "wildcard_pattern_matcher_core_defines.svh"

// Streaming matcher for a pattern of up to MAX_PATTERN_LEN characters where any position
// may be marked as a wildcard. One text character is taken per cycle while in_stall is low
// and gives one result word: whether the window ending at that character matches, and the
// 1-based position at which the window begins (0 when there is no match). Words pass the
// input register, then the result register; all window positions are compared in parallel
// in the single stage between them, giving one word per clock when unstalled. text_start
// clears the history and restarts the position count at 1; the count saturates at
// 2^POSITION_WIDTH - 1. The user must write configuration only while idle (not enforced).
module wildcard_pattern_matcher_core
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN_LEN = 16,
  parameter int POSITION_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // text input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     text_char,
  input  logic                  text_start,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  match_found,
  output logic [OUT_POS_W-1:0]  start_position
);

  localparam int LEN_W      = $clog2(MAX_PATTERN_LEN + 1);
  localparam int IDX_W      = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int HIST_DEPTH = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;
  localparam int SP_W       = (POSITION_WIDTH > OUT_POS_W) ? POSITION_WIDTH : OUT_POS_W;
  localparam logic [LEN_W-1:0]          LEN_MAX = LEN_W'(MAX_PATTERN_LEN);
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  // configuration registers
  logic [CFG_DATA_W-1:0] chars_low;
  logic [CFG_DATA_W-1:0] chars_high;
  logic [MASK_W-1:0]     wild_mask;
  logic [LEN_REG_W-1:0]  pat_len;

  // input register
  logic              in_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              start_q;

  // text state
  logic [CHAR_W-1:0]         hist [HIST_DEPTH];
  logic [LEN_W-1:0]          chars_seen;
  logic [POSITION_WIDTH-1:0] text_position;

  // compare stage
  logic                      adv;
  logic [CHAR_W-1:0]         hist_base [HIST_DEPTH];
  logic [CHAR_W-1:0]         win [MAX_PATTERN_LEN];
  logic [2*CFG_DATA_W-1:0]   pat_bits;
  logic [LEN_W-1:0]          len_eff;
  logic [LEN_W-1:0]          seen_base;
  logic [LEN_W-1:0]          chars_seen_next;
  logic [POSITION_WIDTH-1:0] pos_base;
  logic [POSITION_WIDTH-1:0] text_position_next;
  logic [MAX_PATTERN_LEN-1:0] pos_ok;
  logic [LEN_W-1:0]          diff [MAX_PATTERN_LEN];
  logic                      match_next;
  logic [POSITION_WIDTH-1:0] sp;
  logic [SP_W-1:0]           sp_wide;

  // handshake: the input register moves on whenever the result register is free or drains
  assign adv      = in_valid_q && (!out_valid || !out_stall);
  assign in_stall = in_valid_q && out_valid && out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_low  <= '0;
      chars_high <= '0;
      wild_mask  <= '0;
      pat_len    <= LEN_REG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CHARS_LOW:  chars_low  <= cfg_data;
        CFG_CHARS_HIGH: chars_high <= cfg_data;
        CFG_WILD_MASK:  wild_mask  <= cfg_data[MASK_W-1:0];
        CFG_PAT_LEN:    pat_len    <= cfg_data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective pattern length, clamped to 1..MAX_PATTERN_LEN
  always_comb begin
    if (pat_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (pat_len > LEN_REG_W'(MAX_PATTERN_LEN)) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = pat_len[LEN_W-1:0];
    end
  end

  assign pat_bits = {chars_high, chars_low};

  // state as seen by this word, after a possible text restart
  always_comb begin
    for (int j = 0; j < HIST_DEPTH; j++) begin
      hist_base[j] = start_q ? '0 : hist[j];
    end
    seen_base = start_q ? '0 : chars_seen;
    pos_base  = start_q ? '0 : text_position;
    chars_seen_next    = (seen_base == LEN_MAX) ? seen_base : seen_base + LEN_W'(1);
    text_position_next = (pos_base == POS_MAX) ? pos_base
                                               : pos_base + POSITION_WIDTH'(1);
  end

  // window, newest character first
  always_comb begin
    win[0] = char_q;
    for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
      win[j] = hist_base[j-1];
    end
  end

  // per-position compare, wildcards and unused positions always pass
  always_comb begin
    for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
      diff[k] = len_eff - LEN_W'(k) - LEN_W'(1);
      if (LEN_W'(k) >= len_eff || wild_mask[k]) begin
        pos_ok[k] = 1'b1;
      end else begin
        pos_ok[k] = (win[diff[k][IDX_W-1:0]] == pat_bits[CHAR_W*k +: CHAR_W]);
      end
    end
    match_next = (chars_seen_next >= len_eff) && (&pos_ok);
    sp         = text_position_next - POSITION_WIDTH'(len_eff) + POSITION_WIDTH'(1);
    sp_wide    = SP_W'(sp);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      char_q  <= text_char;
      start_q <= text_start;
    end
  end

  // text state update as each word completes
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_seen    <= '0;
      text_position <= '0;
      for (int j = 0; j < HIST_DEPTH; j++) begin
        hist[j] <= '0;
      end
    end else if (adv) begin
      chars_seen    <= chars_seen_next;
      text_position <= text_position_next;
      hist[0]       <= char_q;
      for (int j = 1; j < HIST_DEPTH; j++) begin
        hist[j] <= hist_base[j-1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      match_found    <= match_next;
      start_position <= match_next ? sp_wide[OUT_POS_W-1:0] : '0;
    end
  end

  // checks
  `WPM_ASSERT_NOW(a_nomatch_zero_pos, clk, rst, out_valid && !match_found,
                  start_position == '0)
  `WPM_ASSERT_NEXT(a_adv_gives_result, clk, rst, adv, out_valid)
  `WPM_ASSERT_NEXT(a_pos_monotonic, clk, rst, adv && !start_q,
                   text_position >= $past(text_position))

endmodule
